[src/rgb_to_yuv420_planar_defines.svh]
// assertion macros for the rgb to yuv 4:2:0 converter
`ifndef RGB_TO_YUV420_PLANAR_DEFINES_SVH
`define RGB_TO_YUV420_PLANAR_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent holds in a cycle, consequent holds in the same cycle
`define RGBYUV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds in a cycle, consequent holds in the next cycle
`define RGBYUV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define RGBYUV_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define RGBYUV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/rgbyuv_pkg.sv]
package rgbyuv_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int DIM_W     = 13;
   localparam int CNT_W     = $clog2(MAX_DIM);
   localparam int LPTR_W    = 24;
   localparam int CPTR_W    = 25;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;
   localparam int SUM_W     = 17;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int RESET_AREA   = RESET_WIDTH * RESET_HEIGHT;
   localparam int RESET_VBASE  = RESET_AREA + RESET_AREA / 4;

   // register index, taken from paddr[2]
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // chroma kind codes
   localparam logic [1:0] CHROMA_NONE = 2'd0;
   localparam logic [1:0] CHROMA_U    = 2'd1;
   localparam logic [1:0] CHROMA_V    = 2'd2;

   // bt.601 studio range coefficients
   localparam int Y_R = 66;
   localparam int Y_G = 129;
   localparam int Y_B = 25;
   localparam int U_R = 38;
   localparam int U_G = 74;
   localparam int U_B = 112;
   localparam int V_R = 112;
   localparam int V_G = 94;
   localparam int V_B = 18;
   localparam int ROUND      = 128;
   localparam int Y_OFFSET   = 16;
   localparam int C_BIAS     = 32768 + ROUND;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_word_type;

   typedef struct packed {
      logic [7:0]        luma;
      logic [LPTR_W-1:0] luma_offset;
      logic [1:0]        chroma_kind;
      logic [7:0]        chroma;
      logic [CPTR_W-1:0] chroma_offset;
      logic              frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic [DIM_W-1:0]  eff_width;
      logic [DIM_W-1:0]  eff_height;
      logic [CPTR_W-1:0] area;
      logic [CPTR_W-1:0] v_base;
      logic              restart;
      logic [CPTR_W-1:0] area_next;
      logic [CPTR_W-1:0] v_base_next;
   } cfg_type;

   typedef struct packed {
      logic [LPTR_W-1:0] luma_offset;
      logic [1:0]        chroma_kind;
      logic [CPTR_W-1:0] chroma_offset;
      logic              frame_end;
   } pos_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v < DIM_W'(2)) begin
         r = DIM_W'(2);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[src/rgbyuv_csr.sv]
module rgbyuv_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rgbyuv_pkg::ADDR_W-1:0] paddr,
   input  logic [rgbyuv_pkg::DATA_W-1:0] pwdata,
   output logic [rgbyuv_pkg::DATA_W-1:0] prdata,
   output logic                         pready,
   output rgbyuv_pkg::cfg_type          cfg
);
   import rgbyuv_pkg::*;

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [CPTR_W-1:0]  area_ff, area_in;
   logic [CPTR_W-1:0]  vbase_ff, vbase_in;
   logic [2*DIM_W-1:0] prod;
   logic               wr;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite & pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         unique case (paddr[2])
            REG_WIDTH:  width_in  = pwdata[DIM_W-1:0];
            REG_HEIGHT: height_in = pwdata[DIM_W-1:0];
            default:    width_in  = width_ff;
         endcase
      end
      prod     = (2*DIM_W)'(eff_dim(width_in)) * (2*DIM_W)'(eff_dim(height_in));
      area_in  = prod[CPTR_W-1:0];
      vbase_in = area_in + (area_in >> 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(RESET_WIDTH);
         height_ff <= DIM_W'(RESET_HEIGHT);
         area_ff   <= CPTR_W'(RESET_AREA);
         vbase_ff  <= CPTR_W'(RESET_VBASE);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         area_ff   <= area_in;
         vbase_ff  <= vbase_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_WIDTH:  prdata = DATA_W'(width_ff);
         REG_HEIGHT: prdata = DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   assign cfg.eff_width   = eff_dim(width_ff);
   assign cfg.eff_height  = eff_dim(height_ff);
   assign cfg.area        = area_ff;
   assign cfg.v_base      = vbase_ff;
   assign cfg.restart     = wr;
   assign cfg.area_next   = area_in;
   assign cfg.v_base_next = vbase_in;

endmodule

[src/rgbyuv_pos.sv]
module rgbyuv_pos (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  rgbyuv_pkg::cfg_type cfg,
   output rgbyuv_pkg::pos_type pos
);
   import rgbyuv_pkg::*;

   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [LPTR_W-1:0] lptr_ff, lptr_in;
   logic [CPTR_W-1:0] uptr_ff, uptr_in;
   logic [CPTR_W-1:0] vptr_ff, vptr_in;
   logic              col_last, row_last;
   logic [1:0]        kind;

   assign col_last = ({1'b0, col_ff} + DIM_W'(1)) >= cfg.eff_width;
   assign row_last = ({1'b0, row_ff} + DIM_W'(1)) >= cfg.eff_height;

   always_comb begin
      if (col_ff[0]) begin
         kind = CHROMA_NONE;
      end else if (row_ff[0]) begin
         kind = CHROMA_V;
      end else begin
         kind = CHROMA_U;
      end
   end

   always_comb begin
      pos.luma_offset = lptr_ff;
      pos.chroma_kind = kind;
      pos.frame_end   = col_last & row_last;
      case (kind)
         CHROMA_U: pos.chroma_offset = uptr_ff;
         CHROMA_V: pos.chroma_offset = vptr_ff;
         default:  pos.chroma_offset = '0;
      endcase
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      lptr_in = lptr_ff;
      uptr_in = uptr_ff;
      vptr_in = vptr_ff;
      if (cfg.restart) begin
         col_in  = '0;
         row_in  = '0;
         lptr_in = '0;
         uptr_in = cfg.area_next;
         vptr_in = cfg.v_base_next;
      end else if (accept) begin
         if (pos.frame_end) begin
            col_in  = '0;
            row_in  = '0;
            lptr_in = '0;
            uptr_in = cfg.area;
            vptr_in = cfg.v_base;
         end else begin
            lptr_in = lptr_ff + LPTR_W'(1);
            if (kind == CHROMA_U) begin
               uptr_in = uptr_ff + CPTR_W'(1);
            end
            if (kind == CHROMA_V) begin
               vptr_in = vptr_ff + CPTR_W'(1);
            end
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + CNT_W'(1);
            end else begin
               col_in = col_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         lptr_ff <= '0;
         uptr_ff <= CPTR_W'(RESET_AREA);
         vptr_ff <= CPTR_W'(RESET_VBASE);
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         lptr_ff <= lptr_in;
         uptr_ff <= uptr_in;
         vptr_ff <= vptr_in;
      end
   end

endmodule

[src/rgbyuv_color.sv]
module rgbyuv_color (
   input  rgbyuv_pkg::req_word_type pixel,
   output logic [7:0]               luma,
   output logic [7:0]               u_val,
   output logic [7:0]               v_val
);
   import rgbyuv_pkg::*;

   logic [SUM_W-1:0] r, g, b;
   logic [SUM_W-1:0] y_sum, u_sum, v_sum;

   assign r = SUM_W'(pixel.red);
   assign g = SUM_W'(pixel.green);
   assign b = SUM_W'(pixel.blue);

   // the bias keeps chroma sums positive, its upper byte gives the +128
   assign y_sum = r * SUM_W'(Y_R) + g * SUM_W'(Y_G) + b * SUM_W'(Y_B) + SUM_W'(ROUND);
   assign u_sum = b * SUM_W'(U_B) + SUM_W'(C_BIAS) - r * SUM_W'(U_R) - g * SUM_W'(U_G);
   assign v_sum = r * SUM_W'(V_R) + SUM_W'(C_BIAS) - g * SUM_W'(V_G) - b * SUM_W'(V_B);

   assign luma  = y_sum[15:8] + 8'(Y_OFFSET);
   assign u_val = u_sum[15:8];
   assign v_val = v_sum[15:8];

endmodule

[src/rgb_to_yuv420_planar.sv]
// rgb to planar yuv 4:2:0 converter, bt.601 studio range. takes one rgb pixel
// per clock in raster order unless stalled and returns one word per pixel: the
// y byte with its offset in the planar buffer, plus a u sample (even rows) or v
// sample (odd rows) at even columns with its running plane offset. the last
// pixel of a frame is flagged and all counters go back to the frame start.
// throughput is one pixel per clock unless the output stalls; a pixel passes
// the input register, then the color math, then the result register. writing
// frame_width or frame_height restarts the frame; values below 2 act as 2 and
// above 4096 as 4096. no clearing pass is needed after reset
`include "rgb_to_yuv420_planar_defines.svh"

module rgb_to_yuv420_planar (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rgbyuv_pkg::req_word_type      req_data,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rgbyuv_pkg::rsp_word_type      rsp_data,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rgbyuv_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [rgbyuv_pkg::DATA_W-1:0] csr_pwdata,
   output logic [rgbyuv_pkg::DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import rgbyuv_pkg::*;

   cfg_type      cfg;
   pos_type      pos;

   // input stage: pixel plus its buffer position
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_pixel_ff;
   pos_type      s1_pos_ff;

   // result stage
   logic         s2_valid_ff, s2_valid_in;
   rsp_word_type s2_word_ff, s2_word_in;

   logic         req_accept;
   logic         out_free;
   logic         s1_adv;
   logic [7:0]   luma, u_val, v_val;

   rgbyuv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // position counters advance once per accepted pixel
   rgbyuv_pos u_pos (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .cfg    (cfg),
      .pos    (pos)
   );

   rgbyuv_color u_color (
      .pixel (s1_pixel_ff),
      .luma  (luma),
      .u_val (u_val),
      .v_val (v_val)
   );

   // result register frees when empty or when its word is taken
   assign out_free   = ~s2_valid_ff | ~rsp_stall;
   assign s1_adv     = s1_valid_ff & out_free;
   assign req_stall  = s1_valid_ff & ~out_free;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      s2_valid_in = out_free ? s1_valid_ff : s2_valid_ff;
   end

   // assemble the result word; chroma fields are zero when no sample
   always_comb begin
      s2_word_in.luma          = luma;
      s2_word_in.luma_offset   = s1_pos_ff.luma_offset;
      s2_word_in.chroma_kind   = s1_pos_ff.chroma_kind;
      s2_word_in.chroma_offset = s1_pos_ff.chroma_offset;
      s2_word_in.frame_end     = s1_pos_ff.frame_end;
      case (s1_pos_ff.chroma_kind)
         CHROMA_U: s2_word_in.chroma = u_val;
         CHROMA_V: s2_word_in.chroma = v_val;
         default:  s2_word_in.chroma = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_data;
         s1_pos_ff   <= pos;
      end
      if (s1_adv) begin
         s2_word_ff <= s2_word_in;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_word_ff;

   // a result word without a chroma sample carries zero chroma fields
   `RGBYUV_ASSERT_SAME(a_no_chroma_zero, clock, reset,
      rsp_valid && (rsp_data.chroma_kind == CHROMA_NONE),
      (rsp_data.chroma == 8'd0) && (rsp_data.chroma_offset == '0),
      "chroma fields not zero without a sample")

   // an accepted pixel is in the input stage on the next cycle
   `RGBYUV_ASSERT_NEXT(a_accept_fills, clock, reset, req_accept, s1_valid_ff,
      "accepted pixel lost")

   // a stalled input stage keeps its word
   `RGBYUV_ASSERT_NEXT(a_stall_holds, clock, reset, s1_valid_ff && !out_free,
      s1_valid_ff && $stable(s1_pos_ff),
      "input stage changed while stalled")

   // after the last pixel the next pixel starts at luma offset zero
   `RGBYUV_ASSERT_NEXT(a_frame_wrap, clock, reset, req_accept && pos.frame_end,
      pos.luma_offset == '0,
      "luma offset did not wrap at frame end")

endmodule

[tb/rgb_to_yuv420_planar_test.sv]
`timescale 1ns / 100ps

module rgb_to_yuv420_planar_test;
   import rgbyuv_pkg::*;

   // bt.601 color math and planar offsets kept in step with every pixel taken,
   // result words queued in order and compared as they come out
   class yuv_scoreboard;
      logic [DIM_W-1:0]  width_reg;
      logic [DIM_W-1:0]  height_reg;
      int                column;
      int                row;
      logic [LPTR_W-1:0] luma_ptr;
      logic [CPTR_W-1:0] u_ptr;
      logic [CPTR_W-1:0] v_ptr;
      rsp_word_type      expected_words[$];
      int                mismatches;
      int                words_checked;
      int                pixels_seen;

      function new();
         width_reg = DIM_W'(RESET_WIDTH);
         height_reg = DIM_W'(RESET_HEIGHT);
         mismatches = 0;
         words_checked = 0;
         pixels_seen = 0;
         restart_frame();
      endfunction

      function int clamp_dim(logic [DIM_W-1:0] v);
         if (v < 2) begin
            return 2;
         end
         if (v > MAX_DIM) begin
            return MAX_DIM;
         end
         return int'(v);
      endfunction

      function void restart_frame();
         int area;
         area = clamp_dim(width_reg) * clamp_dim(height_reg);
         column = 0;
         row = 0;
         luma_ptr = '0;
         u_ptr = CPTR_W'(area);
         v_ptr = CPTR_W'(area + area / 4);
      endfunction

      function void set_dim(logic idx, logic [DATA_W-1:0] value);
         if (idx == REG_WIDTH) begin
            width_reg = value[DIM_W-1:0];
         end else begin
            height_reg = value[DIM_W-1:0];
         end
         restart_frame();
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void note_pixel(req_word_type px);
         int r, g, b, w, h;
         bit last;
         rsp_word_type word;
         r = px.red;
         g = px.green;
         b = px.blue;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         pixels_seen++;
         word.luma = 8'(((66 * r + 129 * g + 25 * b + 128) >> 8) + 16);
         word.luma_offset = luma_ptr;
         word.chroma_kind = CHROMA_NONE;
         word.chroma = '0;
         word.chroma_offset = '0;
         if (column % 2 == 0) begin
            if (row % 2 == 0) begin
               word.chroma_kind = CHROMA_U;
               word.chroma = 8'((112 * b - 38 * r - 74 * g + 32896) >> 8);
               word.chroma_offset = u_ptr;
               u_ptr = u_ptr + 1'b1;
            end else begin
               word.chroma_kind = CHROMA_V;
               word.chroma = 8'((112 * r - 94 * g - 18 * b + 32896) >> 8);
               word.chroma_offset = v_ptr;
               v_ptr = v_ptr + 1'b1;
            end
         end
         last = (column + 1 >= w) && (row + 1 >= h);
         word.frame_end = last;
         expected_words.push_back(word);
         if (last) begin
            restart_frame();
         end else begin
            luma_ptr = luma_ptr + 1'b1;
            if (column + 1 >= w) begin
               column = 0;
               row++;
            end else begin
               column++;
            end
         end
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result word: luma %0d at %0d, kind %0d chroma %0d at %0d",
                        got.luma, got.luma_offset, got.chroma_kind, got.chroma,
                        got.chroma_offset);
            end
            return;
         end
         want = expected_words.pop_front();
         words_checked++;
         if (got.luma !== want.luma || got.luma_offset !== want.luma_offset ||
             got.chroma_kind !== want.chroma_kind || got.chroma !== want.chroma ||
             got.chroma_offset !== want.chroma_offset || got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("word %0d expected: luma %0d at %0d, kind %0d chroma %0d at %0d, end %0b",
                        words_checked, want.luma, want.luma_offset, want.chroma_kind,
                        want.chroma, want.chroma_offset, want.frame_end);
               $display("word %0d actual:   luma %0d at %0d, kind %0d chroma %0d at %0d, end %0b",
                        words_checked, got.luma, got.luma_offset, got.chroma_kind,
                        got.chroma, got.chroma_offset, got.frame_end);
            end
         end
      endfunction

      function void check_register(logic idx, logic [DATA_W-1:0] got);
         logic [DATA_W-1:0] want;
         want = DATA_W'(idx == REG_WIDTH ? width_reg : height_reg);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("register %0d read: expected %0d, actual %0d", idx, want, got);
            end
         end
      endfunction
   endclass

   // clock, reset and block ports, all known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_word_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_word_type         rsp_data;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_W-1:0]    paddr = '0;
   logic [DATA_W-1:0]    pwdata = '0;
   logic [DATA_W-1:0]    prdata;
   logic                 pready;

   yuv_scoreboard board = new();

   // idle knobs, written by the stimulus process only
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int holds_asked = 0;
   int settings_used = 0;

   // owned by the output stall process
   int holds_done = 0;
   int hold_left = 0;

   // primaries, secondaries, black, white, mid gray and near-extreme values
   logic [23:0] corner_colors[12] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                      24'h0000FF, 24'hFFFF00, 24'hFF00FF, 24'h00FFFF,
                                      24'h808080, 24'h010101, 24'hFEFEFE, 24'h7F807F};

   rgb_to_yuv420_planar uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (psel),
      .csr_penable (penable),
      .csr_pwrite  (pwrite),
      .csr_paddr   (paddr),
      .csr_pwdata  (pwdata),
      .csr_prdata  (prdata),
      .csr_pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // output side stall, with long holds counted here so the input backs up
   always @(negedge clock) begin
      if (holds_done < holds_asked) begin
         hold_left = 300;
         holds_done++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // every word taken from the block goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_word(rsp_data);
      end
   end

   // mostly random bytes, with the two extremes favored
   function automatic logic [7:0] pick_component();
      case ($urandom_range(9))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom);
         end
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_pixel(input req_word_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      board.note_pixel(px);
      @(negedge clock);
   endtask

   // drop valid and hold off until every queued word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // two-phase register write, with psel dropped again before the task returns
   task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      board.set_dim(idx, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic read_back(input logic idx);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      board.check_register(idx, prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // new frame size only once the pipe is empty and settled
   task automatic configure(input int w, input int h);
      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      write_reg(REG_WIDTH, DATA_W'(w));
      write_reg(REG_HEIGHT, DATA_W'(h));
      read_back(REG_WIDTH);
      read_back(REG_HEIGHT);
      settings_used++;
   endtask

   task automatic run_phase(input int w, input int h, input int count, input int send_pct,
                            input int recv_pct, input bit long_hold, input bit mid_pause);
      req_word_type px;
      configure(w, h);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      if (long_hold) begin
         holds_asked++;
      end
      for (int i = 0; i < count; i++) begin
         if (mid_pause && i == count / 2) begin
            wait_drained();
         end
         px.red = pick_component();
         px.green = pick_component();
         px.blue = pick_component();
         send_pixel(px);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: 640x480, chroma planes at 307200 and 384000
      read_back(REG_WIDTH);
      read_back(REG_HEIGHT);
      for (int k = 0; k < 4; k++) begin
         send_pixel(corner_colors[k]);
      end

      // smallest frame, two full passes for u, v, frame end and wrap
      configure(2, 2);
      for (int k = 4; k < 12; k++) begin
         send_pixel(corner_colors[k]);
      end

      // sizes below the minimum act as 2
      configure(1, 0);
      for (int k = 0; k < 4; k++) begin
         send_pixel(corner_colors[(k * 5) % 12]);
      end

      // odd sizes, chroma planes overlap
      configure(3, 3);
      for (int k = 0; k < 9; k++) begin
         send_pixel(corner_colors[(k * 7 + 3) % 12]);
      end

      // random pixels over a spread of frame sizes and idle patterns
      run_phase($urandom_range(2, 40), $urandom_range(2, 20), 150, 0, 0, 1'b0, 1'b0);
      run_phase(6, 2, 150, 63, 0, 1'b0, 1'b1);
      run_phase(2, 4096, 150, 0, 63, 1'b0, 1'b0);
      run_phase(4096, 2, 150, 22, 22, 1'b0, 1'b0);
      // above the maximum acts as 4096, all register bits set
      run_phase(8191, 8191, 80, 22, 22, 1'b0, 1'b0);
      run_phase(5, 7, 150, 0, 63, 1'b0, 1'b0);
      run_phase(1, 6, 100, 63, 0, 1'b0, 1'b0);
      // output held off long enough to back the input up
      run_phase(10, 6, 150, 0, 0, 1'b1, 1'b0);

      wait_drained();
      repeat (5) @(posedge clock);

      $display("converted %0d pixels under %0d frame sizes, %0d result words checked",
               board.pixels_seen, settings_used, board.words_checked);
      $display("%s %s", "sizes from 2x2 to 4096 wide or high, clamped and odd,",
               "with idle, stall and hold phases");
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("rgb_to_yuv420_planar_test passed");
      end else begin
         $display("rgb_to_yuv420_planar_test failed");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #2_000_000;
      $display("rgb_to_yuv420_planar_test failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/rgbyuv_pkg.sv
src/rgbyuv_csr.sv
src/rgbyuv_pos.sv
src/rgbyuv_color.sv
src/rgb_to_yuv420_planar.sv
tb/rgb_to_yuv420_planar_test.sv
